### hw/rtl/fss_pkg.sv
// Package for the FASTA stream statistics block: byte codes, limits, mode codes
// and the byte classification type. No dependencies.
package fss_pkg;

   localparam int COUNT_BITS_DEFAULT = 32;
   localparam int SAMPLE_LIMIT       = 1000000;
   localparam logic [31:0] OUT_TOP   = 32'hffff_ffff;

   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_GT    = 8'h3e;
   localparam logic [7:0] CHAR_LT    = 8'h3c;
   localparam logic [7:0] CHAR_EQ    = 8'h3d;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   typedef enum logic [1:0] {
      MODE_AUTO       = 2'd0,
      MODE_NUCLEOTIDE = 2'd1,
      MODE_PROTEIN    = 2'd2,
      MODE_SPARE      = 2'd3
   } mode_type;

   typedef struct packed {
      logic gt;
      logic lf;
      logic skip;
      logic letter;
      logic nucleotide;
      logic bad;
   } byte_class_type;

endpackage

### hw/rtl/fss_classify.sv
// Byte classifier for the FASTA stream statistics block.
// Depends on fss_pkg for byte codes and the classification struct.
module fss_classify (
   input  logic [7:0]              text_byte,
   output fss_pkg::byte_class_type byte_class
);

   logic       is_upper;
   logic [7:0] lower;

   always_comb begin
      is_upper = text_byte inside {[8'h41:8'h5a]};
      lower    = is_upper ? (text_byte | fss_pkg::CASE_BIT) : text_byte;
      byte_class.gt     = text_byte == fss_pkg::CHAR_GT;
      byte_class.lf     = text_byte == fss_pkg::CHAR_LF;
      byte_class.skip   = text_byte inside {fss_pkg::CHAR_LF, fss_pkg::CHAR_CR,
                                            fss_pkg::CHAR_SPACE};
      byte_class.letter = lower inside {[8'h61:8'h7a]};
      byte_class.nucleotide = lower inside {8'h61, 8'h74, 8'h67, 8'h63, 8'h75, 8'h6e};
      byte_class.bad    = text_byte inside {fss_pkg::CHAR_EQ, fss_pkg::CHAR_LT,
                                            fss_pkg::CHAR_GT};
   end

endmodule

### hw/rtl/fasta_stream_statistics.sv
// Top level of the FASTA stream statistics block: byte scan, record close,
// verdict and result register. Depends on fss_pkg and fss_classify.
//
// Usage: the req channel takes one byte of FASTA text per transaction, with
// req_last_byte marking the final byte of a text. Every byte updates the scan
// state in the cycle it is taken, so one byte is taken per cycle while req_ready is high.
// Only the final byte causes a rsp transaction: it carries the record count,
// shortest and longest record length, sampled nucleotide and letter tallies,
// the nucleotide verdict and the format error flag.
// The final byte runs through three registers (snapshot, record close,
// verdict); the snapshot loads at the edge that takes the byte, and the
// verdict register drives rsp_valid.
// The scan state clears as the final byte is taken; the next byte taken
// starts a new text with no gap needed.
// csr_wr_en writes the type mode (auto, force nucleotide, force protein; code 3 acts as auto).
// When the receiver holds rsp_ready low the three stages fill, after which
// req_ready drops until the result is taken.
// reset (synchronous, active high) clears the scan state, the pipeline and
// the type mode.
module fasta_stream_statistics #(
   parameter int COUNT_BITS = fss_pkg::COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_record_count,
   output logic [31:0] rsp_min_length,
   output logic [31:0] rsp_max_length,
   output logic [31:0] rsp_nucleotide_count,
   output logic [31:0] rsp_letter_count,
   output logic        rsp_is_nucleotide,
   output logic        rsp_format_error
);

   localparam int LW = COUNT_BITS + 21;
   localparam int OW = COUNT_BITS + 32;
   localparam int VW = COUNT_BITS + 2;
   localparam logic [COUNT_BITS-1:0] CNT_TOP = '1;

   typedef struct packed {
      logic [COUNT_BITS-1:0] records;
      logic [COUNT_BITS-1:0] shortest;
      logic [COUNT_BITS-1:0] longest;
      logic [COUNT_BITS-1:0] sum_n;
      logic [COUNT_BITS-1:0] sum_l;
   } totals_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] len;
      logic [COUNT_BITS-1:0] nuc;
      logic [COUNT_BITS-1:0] ltr;
   } current_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] x);
      return (x == CNT_TOP) ? x : x + 1'b1;
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                      input logic [COUNT_BITS-1:0] b);
      logic [COUNT_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_BITS] ? CNT_TOP : s[COUNT_BITS-1:0];
   endfunction

   function automatic logic [31:0] out32(input logic [COUNT_BITS-1:0] x);
      logic [OW-1:0] w;
      w = OW'(x);
      return (w > OW'(fss_pkg::OUT_TOP)) ? fss_pkg::OUT_TOP : w[31:0];
   endfunction

   function automatic totals_type close_rec(input totals_type t, input current_type c);
      totals_type r;
      r = t;
      r.records = sat_inc(t.records);
      if (c.len > t.longest) r.longest = c.len;
      if (c.len < t.shortest) r.shortest = c.len;
      if (LW'(t.sum_l) < LW'(fss_pkg::SAMPLE_LIMIT)) begin
         r.sum_n = sat_add(t.sum_n, c.nuc);
         r.sum_l = sat_add(t.sum_l, c.ltr);
      end
      return r;
   endfunction

   localparam totals_type TOTALS_CLEAR = '{records: '0, shortest: '1, longest: '0,
                                           sum_n: '0, sum_l: '0};

   fss_pkg::byte_class_type byte_class;

   fss_classify u_classify (
      .text_byte  (req_text_byte),
      .byte_class (byte_class)
   );

   fss_pkg::mode_type mode_ff;
   logic        line_start_ff, in_header_ff, seen_record_ff, error_seen_ff;
   logic        line_start_in, in_header_in, seen_record_in, error_seen_in;
   totals_type  totals_ff, totals_in, step_totals;
   current_type cur_ff, cur_in, step_cur;
   logic        step_seen, step_error, step_header;

   logic        s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic        adv1, adv2, adv3, req_fire;
   totals_type  s1_totals_ff, s2_totals_ff, s2_totals_in;
   current_type s1_cur_ff;
   logic        s1_seen_ff, s1_error_ff, s2_error_ff;

   logic [VW-1:0] n4, l3;
   logic          verdict_in;

   logic [31:0] rsp_record_count_ff, rsp_min_length_ff, rsp_max_length_ff;
   logic [31:0] rsp_nucleotide_count_ff, rsp_letter_count_ff;
   logic        rsp_is_nucleotide_ff, rsp_format_error_ff;

   assign adv3      = !rsp_valid_ff || rsp_ready;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_ready = adv1;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      step_totals = totals_ff;
      step_cur    = cur_ff;
      step_seen   = seen_record_ff;
      step_error  = error_seen_ff;
      step_header = in_header_ff;
      if (byte_class.gt && line_start_ff) begin
         if (seen_record_ff) begin
            step_totals = close_rec(totals_ff, cur_ff);
            step_cur    = '0;
         end
         step_seen   = 1'b1;
         step_header = 1'b1;
      end else if (in_header_ff) begin
         if (byte_class.lf) step_header = 1'b0;
      end else if (seen_record_ff) begin
         if (byte_class.bad) step_error = 1'b1;
         if (!byte_class.skip) begin
            step_cur.len = sat_inc(cur_ff.len);
            if (byte_class.letter) begin
               step_cur.ltr = sat_inc(cur_ff.ltr);
               if (byte_class.nucleotide) step_cur.nuc = sat_inc(cur_ff.nuc);
            end
         end
      end

      line_start_in  = line_start_ff;
      in_header_in   = in_header_ff;
      seen_record_in = seen_record_ff;
      error_seen_in  = error_seen_ff;
      totals_in      = totals_ff;
      cur_in         = cur_ff;
      if (req_fire) begin
         if (req_last_byte) begin
            line_start_in  = 1'b1;
            in_header_in   = 1'b0;
            seen_record_in = 1'b0;
            error_seen_in  = 1'b0;
            totals_in      = TOTALS_CLEAR;
            cur_in         = '0;
         end else begin
            line_start_in  = byte_class.lf;
            in_header_in   = step_header;
            seen_record_in = step_seen;
            error_seen_in  = step_error;
            totals_in      = step_totals;
            cur_in         = step_cur;
         end
      end
   end

   always_comb begin
      s2_totals_in = s1_seen_ff ? close_rec(s1_totals_ff, s1_cur_ff) : s1_totals_ff;
   end

   always_comb begin
      n4 = {s2_totals_ff.sum_n, 2'b00};
      l3 = {2'b00, s2_totals_ff.sum_l} + {1'b0, s2_totals_ff.sum_l, 1'b0};
      case (mode_ff)
         fss_pkg::MODE_NUCLEOTIDE: verdict_in = 1'b1;
         fss_pkg::MODE_PROTEIN:    verdict_in = 1'b0;
         default:                  verdict_in = n4 > l3;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= fss_pkg::MODE_AUTO;
         line_start_ff  <= 1'b1;
         in_header_ff   <= 1'b0;
         seen_record_ff <= 1'b0;
         error_seen_ff  <= 1'b0;
         totals_ff      <= TOTALS_CLEAR;
         cur_ff         <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) mode_ff <= fss_pkg::mode_type'(csr_wr_data);
         line_start_ff  <= line_start_in;
         in_header_ff   <= in_header_in;
         seen_record_ff <= seen_record_in;
         error_seen_ff  <= error_seen_in;
         totals_ff      <= totals_in;
         cur_ff         <= cur_in;
         if (adv1) s1_valid_ff  <= req_fire && req_last_byte;
         if (adv2) s2_valid_ff  <= s1_valid_ff;
         if (adv3) rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_totals_ff <= step_totals;
         s1_cur_ff    <= step_cur;
         s1_seen_ff   <= step_seen;
         s1_error_ff  <= step_error;
      end
      if (adv2) begin
         s2_totals_ff <= s2_totals_in;
         s2_error_ff  <= s1_error_ff;
      end
      if (adv3) begin
         rsp_record_count_ff     <= out32(s2_totals_ff.records);
         rsp_min_length_ff       <= (s2_totals_ff.records == '0) ? fss_pkg::OUT_TOP
                                                                 : out32(s2_totals_ff.shortest);
         rsp_max_length_ff       <= out32(s2_totals_ff.longest);
         rsp_nucleotide_count_ff <= out32(s2_totals_ff.sum_n);
         rsp_letter_count_ff     <= out32(s2_totals_ff.sum_l);
         rsp_is_nucleotide_ff    <= verdict_in;
         rsp_format_error_ff     <= s2_error_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_record_count     = rsp_record_count_ff;
   assign rsp_min_length       = rsp_min_length_ff;
   assign rsp_max_length       = rsp_max_length_ff;
   assign rsp_nucleotide_count = rsp_nucleotide_count_ff;
   assign rsp_letter_count     = rsp_letter_count_ff;
   assign rsp_is_nucleotide    = rsp_is_nucleotide_ff;
   assign rsp_format_error     = rsp_format_error_ff;

`ifndef SYNTHESIS
   a_last_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_last_byte |=> s1_valid_ff)
      else $error("last byte transaction did not enter the snapshot stage");

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && s2_valid_ff && rsp_valid_ff)
      else $error("request stalled with an empty pipeline stage");

   a_min_needs_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_min_length != fss_pkg::OUT_TOP |-> rsp_record_count != 32'd0)
      else $error("minimum length reported without any record");

   a_nuc_within_letters: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_nucleotide_count <= rsp_letter_count)
      else $error("nucleotide tally exceeds letter tally");
`endif

endmodule

### test/fasta_stats_checker.sv
// Checker for the FASTA stream statistics block: tracks the byte scan on every req
// transaction, predicts the end-of-text summary and compares each rsp transaction.
// Depends on fss_pkg.
module fasta_stats_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_record_count,
   input  logic [31:0] rsp_min_length,
   input  logic [31:0] rsp_max_length,
   input  logic [31:0] rsp_nucleotide_count,
   input  logic [31:0] rsp_letter_count,
   input  logic        rsp_is_nucleotide,
   input  logic        rsp_format_error,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [31:0] records;
      logic [31:0] min_len;
      logic [31:0] max_len;
      logic [31:0] nuc;
      logic [31:0] letters;
      logic        is_nuc;
      logic        fmt_err;
   } summary_type;

   summary_type       summary_q[$];
   summary_type       want;
   fss_pkg::mode_type mode;
   logic        line_start, in_header, in_record, saw_error;
   logic [31:0] rec_len, rec_nuc, rec_letters;
   logic [31:0] sum_nuc, sum_letters, records, shortest, longest;

   function automatic logic [31:0] bump(input logic [31:0] x);
      return (x == '1) ? x : x + 32'd1;
   endfunction

   function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? '1 : s[31:0];
   endfunction

   task automatic clear_scan();
      line_start  = 1'b1;
      in_header   = 1'b0;
      in_record   = 1'b0;
      saw_error   = 1'b0;
      rec_len     = '0;
      rec_nuc     = '0;
      rec_letters = '0;
      sum_nuc     = '0;
      sum_letters = '0;
      records     = '0;
      shortest    = '1;
      longest     = '0;
   endtask

   task automatic fold_record();
      records = bump(records);
      if (rec_len > longest) longest = rec_len;
      if (rec_len < shortest) shortest = rec_len;
      if (sum_letters < fss_pkg::SAMPLE_LIMIT) begin
         sum_nuc     = add_sat(sum_nuc, rec_nuc);
         sum_letters = add_sat(sum_letters, rec_letters);
      end
      rec_len     = '0;
      rec_nuc     = '0;
      rec_letters = '0;
   endtask

   task automatic scan_byte(input logic [7:0] c, input logic last);
      logic [7:0]  lc;
      logic [33:0] nuc_x4, let_x3;
      summary_type s;
      lc = (c >= "A" && c <= "Z") ? (c | fss_pkg::CASE_BIT) : c;
      if (c == fss_pkg::CHAR_GT && line_start) begin
         if (in_record) fold_record();
         in_record = 1'b1;
         in_header = 1'b1;
      end else if (in_header) begin
         if (c == fss_pkg::CHAR_LF) in_header = 1'b0;
      end else if (in_record) begin
         if (c == fss_pkg::CHAR_EQ || c == fss_pkg::CHAR_LT || c == fss_pkg::CHAR_GT)
            saw_error = 1'b1;
         if (c != fss_pkg::CHAR_LF && c != fss_pkg::CHAR_CR && c != fss_pkg::CHAR_SPACE) begin
            rec_len = bump(rec_len);
            if (lc >= "a" && lc <= "z") begin
               rec_letters = bump(rec_letters);
               case (lc)
                  "a", "t", "g", "c", "u", "n": rec_nuc = bump(rec_nuc);
                  default: ;
               endcase
            end
         end
      end
      line_start = (c == fss_pkg::CHAR_LF);
      if (last) begin
         if (in_record) fold_record();
         nuc_x4 = {sum_nuc, 2'b00};
         let_x3 = {2'b00, sum_letters} + {1'b0, sum_letters, 1'b0};
         case (mode)
            fss_pkg::MODE_NUCLEOTIDE: s.is_nuc = 1'b1;
            fss_pkg::MODE_PROTEIN:    s.is_nuc = 1'b0;
            default:                  s.is_nuc = (nuc_x4 > let_x3);
         endcase
         s.records = records;
         s.min_len = (records == '0) ? fss_pkg::OUT_TOP : shortest;
         s.max_len = longest;
         s.nuc     = sum_nuc;
         s.letters = sum_letters;
         s.fmt_err = saw_error;
         summary_q.push_back(s);
         clear_scan();
      end
   endtask

   task automatic check_field(input string what, input logic [31:0] exp_v,
                              input logic [31:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t %s expected %h actual %h", $time, what, exp_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode = fss_pkg::MODE_AUTO;
         clear_scan();
         summary_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (summary_q.size() == 0) begin
               $display("%0t summary expected none actual record_count %h",
                        $time, rsp_record_count);
               fail_count++;
            end else begin
               want = summary_q.pop_front();
               check_field("record_count", want.records, rsp_record_count);
               check_field("min_length", want.min_len, rsp_min_length);
               check_field("max_length", want.max_len, rsp_max_length);
               check_field("nucleotide_count", want.nuc, rsp_nucleotide_count);
               check_field("letter_count", want.letters, rsp_letter_count);
               check_field("is_nucleotide", 32'(want.is_nuc), 32'(rsp_is_nucleotide));
               check_field("format_error", 32'(want.fmt_err), 32'(rsp_format_error));
            end
         end
         if (csr_wr_en) mode = fss_pkg::mode_type'(csr_wr_data);
         if (req_valid && req_ready) scan_byte(req_text_byte, req_last_byte);
      end
      pending = summary_q.size();
   end

endmodule

### test/tb_top.sv
// Testbench top for the FASTA stream statistics block: clock, reset, FASTA text
// stimulus, type mode writes, receiver stalls, watchdog and verdict.
// Depends on fss_pkg, fasta_stream_statistics and fasta_stats_checker.
module tb_top;

   localparam int IDLE_PCT    = 34;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_BYTES = 90;
   localparam int PHASE_TEXTS = 6;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        csr_wr_en     = 1'b0;
   logic [1:0]  csr_wr_data   = 2'd0;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic [7:0]  req_text_byte = fss_pkg::CHAR_LF;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic [31:0] rsp_record_count, rsp_min_length, rsp_max_length;
   logic [31:0] rsp_nucleotide_count, rsp_letter_count;
   logic        rsp_is_nucleotide, rsp_format_error;
   int          fail_count, pending;
   int          quiet_cycles  = 0;
   logic        calm          = 1'b0;
   logic [7:0]  text_q[$];
   fss_pkg::mode_type phase_modes[4] = '{fss_pkg::MODE_NUCLEOTIDE, fss_pkg::MODE_PROTEIN,
                                         fss_pkg::MODE_SPARE, fss_pkg::MODE_AUTO};

   fasta_stream_statistics dut (.*);
   fasta_stats_checker stats_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles == STALL_LIMIT);
      $display("[fasta_stream_statistics] ERROR");
      $finish;
   end

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      logic took;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      req_last_byte <= last;
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
   endtask

   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
      text_q.delete();
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_mode(input fss_pkg::mode_type m);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [7:0] residue(input logic nuc_rich);
      string      nuc_set;
      string      amino_set;
      string      bad_set;
      int         r;
      logic [7:0] b;
      nuc_set   = "ACGTUN";
      amino_set = "DEFHIKLMPQRSVWY";
      bad_set   = "=<>";
      r = $urandom_range(99);
      if (r < 3) b = fss_pkg::CHAR_SPACE;
      else if (r < 8) b = bad_set[$urandom_range(2)];
      else if (r < 20) b = 8'($urandom_range(255, 1));
      else if (r < (nuc_rich ? 85 : 35)) b = nuc_set[$urandom_range(nuc_set.len() - 1)];
      else b = amino_set[$urandom_range(amino_set.len() - 1)];
      if (b >= "A" && b <= "Z" && $urandom_range(1) == 1) b = b | fss_pkg::CASE_BIT;
      return b;
   endfunction

   task automatic make_text();
      int   kind;
      logic rich;
      text_q.delete();
      kind = $urandom_range(99);
      if (kind < 15) begin
         repeat ($urandom_range(30, 3)) begin
            case ($urandom_range(5))
               0:       text_q.push_back(fss_pkg::CHAR_LF);
               1:       text_q.push_back(fss_pkg::CHAR_GT);
               default: text_q.push_back(8'($urandom_range(255, 1)));
            endcase
         end
      end else begin
         rich = 1'($urandom_range(1));
         if (kind < 25) begin
            repeat ($urandom_range(3, 1)) text_q.push_back(8'($urandom_range(255, 1)));
            text_q.push_back(fss_pkg::CHAR_LF);
         end
         repeat ($urandom_range(2, 1)) begin
            text_q.push_back(fss_pkg::CHAR_GT);
            repeat ($urandom_range(4)) text_q.push_back(8'($urandom_range(126, 33)));
            if ($urandom_range(19) != 0) text_q.push_back(fss_pkg::CHAR_LF);
            repeat ($urandom_range(2)) begin
               repeat ($urandom_range(6)) text_q.push_back(residue(rich));
               if ($urandom_range(3) == 0) text_q.push_back(fss_pkg::CHAR_CR);
               text_q.push_back(fss_pkg::CHAR_LF);
            end
         end
      end
   endtask

   initial begin
      int bytes_sent;
      int texts_sent;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      add_text("Q=\n>a<\nAtGuNC");
      text_q.push_back(8'hff);
      text_q.push_back(fss_pkg::CHAR_CR);
      add_text(" \n>\n=<x>");
      text_q.push_back(8'h01);
      send_text();
      add_text(">");
      send_text();
      add_text("z");
      send_text();

      foreach (phase_modes[p]) begin
         settle();
         set_mode(phase_modes[p]);
         calm <= (phase_modes[p] == fss_pkg::MODE_PROTEIN);
         bytes_sent = 0;
         texts_sent = 0;
         while (bytes_sent < PHASE_BYTES || texts_sent < PHASE_TEXTS) begin
            make_text();
            bytes_sent += text_q.size();
            texts_sent++;
            send_text();
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("[fasta_stream_statistics] OK");
      end else begin
         $display("[fasta_stream_statistics] ERROR");
      end
      $finish;
   end

endmodule
